@@ rtl/indirect_block_map_walker_assert.svh @@
// Assertion macros for the indirect block map walker.
// Included by the top level; needs nothing else.
`ifndef INDIRECT_BLOCK_MAP_WALKER_ASSERT_SVH
`define INDIRECT_BLOCK_MAP_WALKER_ASSERT_SVH

// Check a consequence in the same cycle as its cause.
`define IBMW_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check a consequence in the cycle after its cause.
`define IBMW_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/ibmw_pkg.sv @@
// Shared types and codes for the indirect block map walker.
// No dependencies; imported by the top level.
`timescale 1ns / 1ps

package ibmw_pkg;

    localparam int WORD_W         = 32;
    localparam int ADDR_W         = 44;
    localparam int CFG_W          = 4;
    localparam int OP_W           = 3;
    localparam int SLOT_IN_W      = 4;
    localparam int KIND_W         = 3;
    localparam int STATUS_W       = 2;
    localparam int MIN_WORDS_LOG2 = 8;

    // Input operations
    localparam logic [OP_W-1:0] OP_SET_ROOT    = 3'd0;
    localparam logic [OP_W-1:0] OP_READ_ROOT   = 3'd1;
    localparam logic [OP_W-1:0] OP_LOOKUP      = 3'd2;
    localparam logic [OP_W-1:0] OP_LOOKUP_ALLOC = 3'd3;
    localparam logic [OP_W-1:0] OP_READ_RESP   = 3'd4;
    localparam logic [OP_W-1:0] OP_ALLOC_RESP  = 3'd5;

    // Result kinds
    localparam logic [KIND_W-1:0] KIND_DONE       = 3'd0;
    localparam logic [KIND_W-1:0] KIND_READ_WORD  = 3'd1;
    localparam logic [KIND_W-1:0] KIND_WRITE_WORD = 3'd2;
    localparam logic [KIND_W-1:0] KIND_ZERO_BLOCK = 3'd3;
    localparam logic [KIND_W-1:0] KIND_ALLOC_REQ  = 3'd4;
    localparam logic [KIND_W-1:0] KIND_ROOT_VALUE = 3'd5;

    // Done statuses
    localparam logic [STATUS_W-1:0] ST_OK         = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NOT_MAPPED = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NO_SPACE   = 2'd2;
    localparam logic [STATUS_W-1:0] ST_TOO_BIG    = 2'd3;

    typedef struct packed {
        logic [OP_W-1:0]      op;
        logic [SLOT_IN_W-1:0] slot;
        logic [WORD_W-1:0]    root_value;
        logic [WORD_W-1:0]    file_block_index;
        logic [WORD_W-1:0]    read_word;
        logic [WORD_W-1:0]    new_block;
    } in_item_t;

    typedef struct packed {
        logic [KIND_W-1:0]   kind;
        logic [ADDR_W-1:0]   word_address;
        logic [WORD_W-1:0]   write_word;
        logic [WORD_W-1:0]   block_number;
        logic [STATUS_W-1:0] status;
        logic                last;
    } out_item_t;

endpackage

@@ rtl/indirect_block_map_walker.sv @@
// Top level of the indirect block map walker: root pointer memory, walk
// sequencer and output register. Depends on ibmw_pkg and the assertion header.
`timescale 1ns / 1ps
//
//  channel | handshake             | payload
//  --------+-----------------------+-------------------------------
//  in      | in_valid / in_stall   | in_item  (ibmw_pkg::in_item_t)
//  out     | out_valid / out_stall | out_item (ibmw_pkg::out_item_t)
//  cfg     | cfg_wr_en             | cfg_wr_data (words per block log2)
//
// One item at a time: each accepted item passes through the execute step;
// read root and lookups that fit add a root step for the registered root
// memory read; a granted allocator response adds a tail step with a root
// parent, and a zero step then a tail step with a table word parent. Reset
// clears the root valid bits at once, so no clearing pass. A stalled output
// holds the sequencer in its current step.

module indirect_block_map_walker #(
    parameter int DIRECT_SLOTS   = 12,
    parameter int MAX_WORDS_LOG2 = 12
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  ibmw_pkg::in_item_t     in_item,
    output logic                   out_valid,
    input  logic                   out_stall,
    output ibmw_pkg::out_item_t    out_item,
    input  logic                   cfg_wr_en,
    input  logic [ibmw_pkg::CFG_W-1:0] cfg_wr_data
);

    import ibmw_pkg::*;

    localparam int ROOT_SLOTS = DIRECT_SLOTS + 3;
    localparam int SLOT_W     = $clog2(ROOT_SLOTS);
    localparam int OFF_W      = MAX_WORDS_LOG2;
    localparam int WPB_W      = $clog2(MAX_WORDS_LOG2 + 1);
    localparam int SHW        = WPB_W + 2;
    localparam int EW         = (3 * MAX_WORDS_LOG2 + 1 > 34) ? 3 * MAX_WORDS_LOG2 + 1 : 34;
    localparam int SH_W       = WORD_W + MAX_WORDS_LOG2;

    localparam logic [SLOT_W-1:0] SLOT_SINGLE = SLOT_W'(DIRECT_SLOTS);
    localparam logic [SLOT_W-1:0] SLOT_DOUBLE = SLOT_W'(DIRECT_SLOTS + 1);
    localparam logic [SLOT_W-1:0] SLOT_TRIPLE = SLOT_W'(DIRECT_SLOTS + 2);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_ROOT,
        S_ZERO,
        S_TAIL
    } state_t;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_READ,
        PH_ALLOC
    } phase_t;

    // Registers and next values
    state_t                   state_reg, state_next;
    phase_t                   phase_reg, phase_next;
    in_item_t                 item_reg, item_next;
    logic [WPB_W-1:0]         wpb_reg, wpb_next;
    logic [1:0]               levels_left_reg, levels_left_next;
    logic [2:0][OFF_W-1:0]    offs_reg, offs_next;
    logic [ADDR_W-1:0]        parent_addr_reg, parent_addr_next;
    logic                     parent_root_reg, parent_root_next;
    logic [SLOT_W-1:0]        pend_slot_reg, pend_slot_next;
    logic                     alloc_mode_reg, alloc_mode_next;
    logic [SLOT_W-1:0]        lk_slot_reg, lk_slot_next;
    logic [1:0]               lk_k_reg, lk_k_next;
    logic                     tail_done_reg, tail_done_next;
    logic                     rd_hit_reg, rd_hit_next;
    logic [ROOT_SLOTS-1:0]    root_valid_reg, root_valid_next;
    logic                     out_valid_reg, out_valid_next;
    out_item_t                out_reg, out_next;

    // Root pointer memory
    logic [WORD_W-1:0]        root_mem [ROOT_SLOTS];
    logic [WORD_W-1:0]        rd_q_reg;
    logic                     mem_we;
    logic [SLOT_W-1:0]        mem_waddr;
    logic [WORD_W-1:0]        mem_wdata;
    logic                     mem_re;
    logic [SLOT_W-1:0]        mem_raddr;

    // Index decode
    logic [EW-1:0]            idx_e, per_e, sq_e, cu_e, lim1, lim2, lim3, r0, r1, r2, rsel;
    logic [SHW-1:0]           w2, w3;
    logic [OFF_W-1:0]         mask_off;
    logic                     dec_too_big;
    logic [1:0]               dec_k;
    logic [SLOT_W-1:0]        dec_slot;
    logic [2:0][OFF_W-1:0]    dec_offs;

    logic                     out_free;
    logic                     slot_ok;
    logic [1:0]               ll_dec;
    logic [WORD_W-1:0]        root_p;

    function automatic logic [ADDR_W-1:0] word_addr(input logic [WORD_W-1:0] blk,
                                                    input logic [OFF_W-1:0]  off,
                                                    input logic [WPB_W-1:0]  w);
        logic [SH_W-1:0] sh;
        sh = SH_W'(blk) << w;
        return ADDR_W'(sh) + ADDR_W'(off);
    endfunction

    function automatic logic [OFF_W-1:0] offset_for(input logic [1:0]            k,
                                                    input logic [2:0][OFF_W-1:0] o);
        logic [OFF_W-1:0] r;
        case (k)
            2'd0, 2'd1: r = o[0];
            2'd2:       r = o[1];
            default:    r = o[2];
        endcase
        return r;
    endfunction

    function automatic out_item_t mk_res(input logic [KIND_W-1:0]   kind,
                                         input logic [ADDR_W-1:0]   addr,
                                         input logic [WORD_W-1:0]   ww,
                                         input logic [WORD_W-1:0]   blk,
                                         input logic [STATUS_W-1:0] st,
                                         input logic                lst);
        out_item_t r;
        r.kind         = kind;
        r.word_address = addr;
        r.write_word   = ww;
        r.block_number = blk;
        r.status       = st;
        r.last         = lst;
        return r;
    endfunction

    // Split the file block index into tree, depth and per-level offsets
    always_comb
    begin
        idx_e    = EW'(item_reg.file_block_index);
        w2       = SHW'(wpb_reg) << 1;
        w3       = w2 + SHW'(wpb_reg);
        per_e    = EW'(1) << wpb_reg;
        sq_e     = EW'(1) << w2;
        cu_e     = EW'(1) << w3;
        lim1     = per_e | EW'(DIRECT_SLOTS);
        lim2     = sq_e | lim1;
        lim3     = cu_e | lim2;
        r0       = idx_e - EW'(DIRECT_SLOTS);
        r1       = idx_e - lim1;
        r2       = idx_e - lim2;
        mask_off = ~({OFF_W{1'b1}} << wpb_reg);
        dec_too_big = 1'b0;
        rsel     = r0;
        dec_k    = 2'd0;
        dec_slot = SLOT_W'(item_reg.file_block_index);
        if (idx_e < EW'(DIRECT_SLOTS))
        begin
            dec_k = 2'd0;
        end
        else if (idx_e < lim1)
        begin
            dec_k    = 2'd1;
            dec_slot = SLOT_SINGLE;
        end
        else if (idx_e < lim2)
        begin
            dec_k    = 2'd2;
            dec_slot = SLOT_DOUBLE;
            rsel     = r1;
        end
        else if (idx_e < lim3)
        begin
            dec_k    = 2'd3;
            dec_slot = SLOT_TRIPLE;
            rsel     = r2;
        end
        else
        begin
            dec_too_big = 1'b1;
        end
        dec_offs[0] = OFF_W'(rsel) & mask_off;
        dec_offs[1] = OFF_W'(rsel >> wpb_reg) & mask_off;
        dec_offs[2] = OFF_W'(rsel >> w2) & mask_off;
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_item  = out_reg;

    assign out_free = !out_valid_reg || !out_stall;
    assign slot_ok  = (item_reg.slot < SLOT_IN_W'(ROOT_SLOTS));
    assign ll_dec   = (levels_left_reg != 2'd0) ? levels_left_reg - 2'd1 : 2'd0;
    assign root_p   = rd_hit_reg ? rd_q_reg : '0;

    // Walk sequencer
    always_comb
    begin
        state_next       = state_reg;
        phase_next       = phase_reg;
        item_next        = item_reg;
        levels_left_next = levels_left_reg;
        offs_next        = offs_reg;
        parent_addr_next = parent_addr_reg;
        parent_root_next = parent_root_reg;
        pend_slot_next   = pend_slot_reg;
        alloc_mode_next  = alloc_mode_reg;
        lk_slot_next     = lk_slot_reg;
        lk_k_next        = lk_k_reg;
        tail_done_next   = tail_done_reg;
        root_valid_next  = root_valid_reg;
        mem_we           = 1'b0;
        mem_waddr        = pend_slot_reg;
        mem_wdata        = item_reg.new_block;
        mem_re           = 1'b0;
        mem_raddr        = lk_slot_reg;
        out_next         = out_reg;
        out_valid_next   = out_valid_reg && out_stall;

        // Configuration write, saturated into the supported range
        wpb_next = wpb_reg;
        if (cfg_wr_en)
        begin
            if (cfg_wr_data < MIN_WORDS_LOG2)
                wpb_next = WPB_W'(MIN_WORDS_LOG2);
            else if (cfg_wr_data > MAX_WORDS_LOG2)
                wpb_next = WPB_W'(MAX_WORDS_LOG2);
            else
                wpb_next = WPB_W'(cfg_wr_data);
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    item_next  = in_item;
                    state_next = S_EXEC;
                end
            end

            S_EXEC:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                    case (item_reg.op)
                        OP_SET_ROOT:
                        begin
                            if (slot_ok)
                            begin
                                mem_we    = 1'b1;
                                mem_waddr = SLOT_W'(item_reg.slot);
                                mem_wdata = item_reg.root_value;
                                root_valid_next[SLOT_W'(item_reg.slot)] = 1'b1;
                            end
                            out_valid_next = 1'b1;
                            out_next = mk_res(KIND_DONE, '0, '0, '0, ST_OK, 1'b1);
                        end

                        OP_READ_ROOT:
                        begin
                            mem_re     = 1'b1;
                            mem_raddr  = slot_ok ? SLOT_W'(item_reg.slot) : '0;
                            state_next = S_ROOT;
                        end

                        OP_LOOKUP, OP_LOOKUP_ALLOC:
                        begin
                            alloc_mode_next  = (item_reg.op == OP_LOOKUP_ALLOC);
                            parent_root_next = 1'b0;
                            phase_next       = PH_IDLE;
                            if (dec_too_big)
                            begin
                                out_valid_next = 1'b1;
                                out_next = mk_res(KIND_DONE, '0, '0, '0, ST_TOO_BIG, 1'b1);
                            end
                            else
                            begin
                                offs_next    = dec_offs;
                                lk_k_next    = dec_k;
                                lk_slot_next = dec_slot;
                                mem_re       = 1'b1;
                                mem_raddr    = dec_slot;
                                state_next   = S_ROOT;
                            end
                        end

                        OP_READ_RESP:
                        begin
                            if (phase_reg == PH_READ)
                            begin
                                levels_left_next = ll_dec;
                                out_valid_next   = 1'b1;
                                if (item_reg.read_word != '0)
                                begin
                                    if (ll_dec == 2'd0)
                                    begin
                                        phase_next = PH_IDLE;
                                        out_next = mk_res(KIND_DONE, '0, '0,
                                                          item_reg.read_word, ST_OK, 1'b1);
                                    end
                                    else
                                    begin
                                        // Descend: read the next level's pointer
                                        parent_addr_next = word_addr(item_reg.read_word,
                                                                     offset_for(ll_dec, offs_reg),
                                                                     wpb_reg);
                                        out_next = mk_res(KIND_READ_WORD, parent_addr_next,
                                                          '0, '0, ST_OK, 1'b1);
                                    end
                                end
                                else if (!alloc_mode_reg)
                                begin
                                    phase_next = PH_IDLE;
                                    out_next = mk_res(KIND_DONE, '0, '0, '0, ST_NOT_MAPPED, 1'b1);
                                end
                                else
                                begin
                                    parent_root_next = 1'b0;
                                    phase_next       = PH_ALLOC;
                                    out_next = mk_res(KIND_ALLOC_REQ, '0, '0, '0, ST_OK, 1'b1);
                                end
                            end
                        end

                        OP_ALLOC_RESP:
                        begin
                            if (phase_reg == PH_ALLOC)
                            begin
                                out_valid_next = 1'b1;
                                if (item_reg.new_block == '0)
                                begin
                                    phase_next = PH_IDLE;
                                    out_next = mk_res(KIND_DONE, '0, '0, '0, ST_NO_SPACE, 1'b1);
                                end
                                else
                                begin
                                    // Link the new block into its parent
                                    if (parent_root_reg)
                                    begin
                                        mem_we = 1'b1;
                                        root_valid_next[pend_slot_reg] = 1'b1;
                                        out_next = mk_res(KIND_ZERO_BLOCK, '0, '0,
                                                          item_reg.new_block, ST_OK, 1'b0);
                                        state_next = S_TAIL;
                                    end
                                    else
                                    begin
                                        out_next = mk_res(KIND_WRITE_WORD, parent_addr_reg,
                                                          item_reg.new_block, '0, ST_OK, 1'b0);
                                        state_next = S_ZERO;
                                    end
                                    // Finish, or step one level down into the fresh block
                                    if (levels_left_reg == 2'd0)
                                    begin
                                        tail_done_next = 1'b1;
                                        phase_next     = PH_IDLE;
                                    end
                                    else
                                    begin
                                        tail_done_next   = 1'b0;
                                        parent_addr_next = word_addr(item_reg.new_block,
                                                                     offset_for(levels_left_reg,
                                                                                offs_reg),
                                                                     wpb_reg);
                                        levels_left_next = levels_left_reg - 2'd1;
                                        parent_root_next = 1'b0;
                                    end
                                end
                            end
                        end

                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end

            S_ROOT:
            begin
                if (out_free)
                begin
                    state_next     = S_IDLE;
                    out_valid_next = 1'b1;
                    if (item_reg.op == OP_READ_ROOT)
                    begin
                        out_next = mk_res(KIND_ROOT_VALUE, '0, '0, root_p, ST_OK, 1'b1);
                    end
                    else
                    begin
                        levels_left_next = lk_k_reg;
                        if (root_p != '0)
                        begin
                            if (lk_k_reg == 2'd0)
                            begin
                                out_next = mk_res(KIND_DONE, '0, '0, root_p, ST_OK, 1'b1);
                            end
                            else
                            begin
                                parent_addr_next = word_addr(root_p,
                                                             offset_for(lk_k_reg, offs_reg),
                                                             wpb_reg);
                                phase_next = PH_READ;
                                out_next = mk_res(KIND_READ_WORD, parent_addr_next,
                                                  '0, '0, ST_OK, 1'b1);
                            end
                        end
                        else if (!alloc_mode_reg)
                        begin
                            out_next = mk_res(KIND_DONE, '0, '0, '0, ST_NOT_MAPPED, 1'b1);
                        end
                        else
                        begin
                            pend_slot_next   = lk_slot_reg;
                            parent_root_next = 1'b1;
                            phase_next       = PH_ALLOC;
                            out_next = mk_res(KIND_ALLOC_REQ, '0, '0, '0, ST_OK, 1'b1);
                        end
                    end
                end
            end

            S_ZERO:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_next = mk_res(KIND_ZERO_BLOCK, '0, '0, item_reg.new_block, ST_OK, 1'b0);
                    state_next = S_TAIL;
                end
            end

            S_TAIL:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    if (tail_done_reg)
                        out_next = mk_res(KIND_DONE, '0, '0, item_reg.new_block, ST_OK, 1'b1);
                    else
                        out_next = mk_res(KIND_ALLOC_REQ, '0, '0, '0, ST_OK, 1'b1);
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // Capture the valid bit alongside the memory read
        rd_hit_next = rd_hit_reg;
        if (mem_re)
            rd_hit_next = (item_reg.op != OP_READ_ROOT || slot_ok) && root_valid_reg[mem_raddr];
    end

    // Hold state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            phase_reg       <= PH_IDLE;
            item_reg        <= '0;
            wpb_reg         <= WPB_W'(MIN_WORDS_LOG2);
            levels_left_reg <= '0;
            offs_reg        <= '0;
            parent_addr_reg <= '0;
            parent_root_reg <= 1'b0;
            pend_slot_reg   <= '0;
            alloc_mode_reg  <= 1'b0;
            lk_slot_reg     <= '0;
            lk_k_reg        <= '0;
            tail_done_reg   <= 1'b0;
            rd_hit_reg      <= 1'b0;
            root_valid_reg  <= '0;
            out_valid_reg   <= 1'b0;
            out_reg         <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            phase_reg       <= phase_next;
            item_reg        <= item_next;
            wpb_reg         <= wpb_next;
            levels_left_reg <= levels_left_next;
            offs_reg        <= offs_next;
            parent_addr_reg <= parent_addr_next;
            parent_root_reg <= parent_root_next;
            pend_slot_reg   <= pend_slot_next;
            alloc_mode_reg  <= alloc_mode_next;
            lk_slot_reg     <= lk_slot_next;
            lk_k_reg        <= lk_k_next;
            tail_done_reg   <= tail_done_next;
            rd_hit_reg      <= rd_hit_next;
            root_valid_reg  <= root_valid_next;
            out_valid_reg   <= out_valid_next;
            out_reg         <= out_next;
        end
    end

    // Root pointer memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
            root_mem[mem_waddr] <= mem_wdata;
        if (mem_re)
            rd_q_reg <= root_mem[mem_raddr];
    end

`include "indirect_block_map_walker_assert.svh"

    `IBMW_ASSERT_SAME(a_read_phase_depth, clk, rst_n, phase_reg == PH_READ, levels_left_reg != 2'd0, "read pending with no level left")
    `IBMW_ASSERT_SAME(a_tail_from_alloc, clk, rst_n, state_reg == S_ZERO || state_reg == S_TAIL, item_reg.op == OP_ALLOC_RESP, "allocation tail outside an allocator response")
    `IBMW_ASSERT_NEXT(a_more_after_nonlast, clk, rst_n, state_reg != S_IDLE && out_valid_next && !out_next.last && out_free, state_reg != S_IDLE, "input taken before the final transfer of an item")

endmodule

@@ bench/testbench.sv @@
// Self-checking testbench for the indirect block map walker.
// Needs ibmw_pkg and the indirect_block_map_walker top level; reads no files.
`timescale 1ns / 1ps

module testbench;

    import ibmw_pkg::*;

    localparam int DIRECT          = 12;
    localparam int ROOT_COUNT      = DIRECT + 3;
    localparam int MAX_LOG2        = 12;
    localparam int RESET_CYCLES    = 9;
    localparam int SETTLE_CYCLES   = 10;
    localparam int IDLE_LIMIT      = 1000;
    localparam int ITEMS_PER_SIZE  = 31;
    localparam longint unsigned WORD_SPAN = 64'd1 << 32;

    // Op codes the block does not know; it must drop them
    localparam logic [OP_W-1:0] OP_SPARE_6 = 3'd6;
    localparam logic [OP_W-1:0] OP_SPARE_7 = 3'd7;

    typedef enum logic [1:0] {WALK_IDLE, WALK_READ, WALK_ALLOC} walk_phase_t;

    // Mirror of the walker state; turns each accepted transfer into the
    // results the block owes for it and checks them in order
    class block_map_scoreboard;
        logic [WORD_W-1:0] roots [ROOT_COUNT];
        walk_phase_t       phase;
        int unsigned       levels;
        logic [WORD_W-1:0] offsets [3];
        logic [WORD_W-1:0] table_blk;
        logic [ADDR_W-1:0] parent_addr;
        bit                parent_in_root;
        int unsigned       pending_slot;
        bit                allocating;
        int unsigned       wlog2;
        out_item_t         pending_results [$];
        out_item_t         batch [$];
        int unsigned       mismatches;

        function new();
            foreach (roots[i]) roots[i] = '0;
            foreach (offsets[i]) offsets[i] = '0;
            phase          = WALK_IDLE;
            levels         = 0;
            table_blk      = '0;
            parent_addr    = '0;
            parent_in_root = 1'b0;
            pending_slot   = 0;
            allocating     = 1'b0;
            wlog2          = MIN_WORDS_LOG2;
            mismatches     = 0;
        endfunction

        // Clamp the block size the same way the register does
        function void set_words_log2(logic [CFG_W-1:0] value);
            if (value < MIN_WORDS_LOG2)
                wlog2 = MIN_WORDS_LOG2;
            else if (value > MAX_LOG2)
                wlog2 = MAX_LOG2;
            else
                wlog2 = value;
        endfunction

        function void emit(logic [KIND_W-1:0] kind, logic [ADDR_W-1:0] addr,
                           logic [WORD_W-1:0] wdata, logic [WORD_W-1:0] blk,
                           logic [STATUS_W-1:0] st);
            out_item_t r;
            r.kind         = kind;
            r.word_address = addr;
            r.write_word   = wdata;
            r.block_number = blk;
            r.status       = st;
            r.last         = 1'b0;
            batch.push_back(r);
        endfunction

        function logic [ADDR_W-1:0] addr_of(logic [WORD_W-1:0] blk, logic [WORD_W-1:0] off);
            logic [63:0] a;
            a = ({32'b0, blk} << wlog2) + {32'b0, off};
            return a[ADDR_W-1:0];
        endfunction

        function logic [WORD_W-1:0] offset_at(int unsigned depth);
            int unsigned i;
            i = (depth != 0) ? depth - 1 : 0;
            if (i > 2)
                i = 2;
            return offsets[i];
        endfunction

        function void finish_walk(logic [WORD_W-1:0] blk, logic [STATUS_W-1:0] st);
            phase = WALK_IDLE;
            emit(KIND_DONE, '0, '0, blk, st);
        endfunction

        function void request_read();
            parent_addr = addr_of(table_blk, offset_at(levels));
            phase = WALK_READ;
            emit(KIND_READ_WORD, parent_addr, '0, '0, '0);
        endfunction

        // Split the index into a root slot and per-level offsets
        function void start_walk(bit alloc, logic [WORD_W-1:0] idx);
            longint unsigned per, mask, rem;
            int unsigned     slot_sel, depth;
            logic [WORD_W-1:0] ptr;
            per = 64'd1 << wlog2;
            mask = per - 1;
            allocating = alloc;
            parent_in_root = 1'b0;
            phase = WALK_IDLE;
            if (idx < DIRECT)
            begin
                slot_sel = idx;
                depth = 0;
            end
            else
            begin
                rem = {32'b0, idx} - DIRECT;
                if (rem < per)
                begin
                    slot_sel = DIRECT;
                    depth = 1;
                    offsets[0] = 32'(rem);
                end
                else
                begin
                    rem -= per;
                    if (rem < per * per)
                    begin
                        slot_sel = DIRECT + 1;
                        depth = 2;
                        offsets[1] = 32'(rem >> wlog2);
                        offsets[0] = 32'(rem & mask);
                    end
                    else
                    begin
                        rem -= per * per;
                        if (rem < per * per * per)
                        begin
                            slot_sel = DIRECT + 2;
                            depth = 3;
                            offsets[2] = 32'((rem >> (2 * wlog2)) & mask);
                            offsets[1] = 32'((rem >> wlog2) & mask);
                            offsets[0] = 32'(rem & mask);
                        end
                        else
                        begin
                            finish_walk('0, ST_TOO_BIG);
                            return;
                        end
                    end
                end
            end
            ptr = roots[slot_sel];
            levels = depth;
            if (ptr != '0)
            begin
                if (depth == 0)
                    finish_walk(ptr, ST_OK);
                else
                begin
                    table_blk = ptr;
                    request_read();
                end
                return;
            end
            if (!alloc)
            begin
                finish_walk('0, ST_NOT_MAPPED);
                return;
            end
            pending_slot = slot_sel;
            parent_in_root = 1'b1;
            phase = WALK_ALLOC;
            emit(KIND_ALLOC_REQ, '0, '0, '0, '0);
        endfunction

        function void take_read_word(logic [WORD_W-1:0] rw);
            if (phase != WALK_READ)
                return;
            if (levels > 0)
                levels--;
            if (rw != '0)
            begin
                if (levels == 0)
                    finish_walk(rw, ST_OK);
                else
                begin
                    table_blk = rw;
                    request_read();
                end
            end
            else if (!allocating)
                finish_walk('0, ST_NOT_MAPPED);
            else
            begin
                parent_in_root = 1'b0;
                phase = WALK_ALLOC;
                emit(KIND_ALLOC_REQ, '0, '0, '0, '0);
            end
        endfunction

        // Link the new block into its parent, clear it, then finish or go down a level
        function void take_new_block(logic [WORD_W-1:0] nb);
            if (phase != WALK_ALLOC)
                return;
            if (nb == '0)
            begin
                finish_walk('0, ST_NO_SPACE);
                return;
            end
            if (parent_in_root)
            begin
                if (pending_slot < ROOT_COUNT)
                    roots[pending_slot] = nb;
            end
            else
                emit(KIND_WRITE_WORD, parent_addr, nb, '0, '0);
            emit(KIND_ZERO_BLOCK, '0, '0, nb, '0);
            if (levels == 0)
                finish_walk(nb, ST_OK);
            else
            begin
                table_blk = nb;
                parent_addr = addr_of(nb, offset_at(levels));
                levels--;
                parent_in_root = 1'b0;
                emit(KIND_ALLOC_REQ, '0, '0, '0, '0);
            end
        endfunction

        function int unsigned note_input(in_item_t it);
            batch.delete();
            case (it.op)
                OP_SET_ROOT:
                begin
                    if (it.slot < ROOT_COUNT)
                        roots[it.slot] = it.root_value;
                    emit(KIND_DONE, '0, '0, '0, ST_OK);
                end
                OP_READ_ROOT:
                    emit(KIND_ROOT_VALUE, '0, '0,
                         (it.slot < ROOT_COUNT) ? roots[it.slot] : '0, '0);
                OP_LOOKUP, OP_LOOKUP_ALLOC:
                    start_walk(it.op == OP_LOOKUP_ALLOC, it.file_block_index);
                OP_READ_RESP:
                    take_read_word(it.read_word);
                OP_ALLOC_RESP:
                    take_new_block(it.new_block);
                default:
                    ;
            endcase
            if (batch.size() != 0)
                batch[$].last = 1'b1;
            foreach (batch[i])
                pending_results.push_back(batch[i]);
            return batch.size();
        endfunction

        function void report(string what, out_item_t want, out_item_t got);
            mismatches++;
            if (mismatches <= 10)
                $display("scoreboard: %s at %0t: expected kind %0d addr %h wdata %h blk %h st %0d last %0d, got kind %0d addr %h wdata %h blk %h st %0d last %0d",
                         what, $realtime, want.kind, want.word_address, want.write_word,
                         want.block_number, want.status, want.last, got.kind,
                         got.word_address, got.write_word, got.block_number, got.status,
                         got.last);
        endfunction

        function void check_result(out_item_t got);
            out_item_t want;
            if (pending_results.size() == 0)
            begin
                report("unexpected result", '0, got);
                return;
            end
            want = pending_results.pop_front();
            if (got.kind !== want.kind || got.word_address !== want.word_address ||
                got.write_word !== want.write_word || got.block_number !== want.block_number ||
                got.status !== want.status || got.last !== want.last)
                report("mismatch", want, got);
        endfunction
    endclass

    logic                clk         = 1'b0;
    logic                rst_n       = 1'b0;
    logic                in_valid    = 1'b0;
    logic                in_stall;
    in_item_t            in_item     = '0;
    logic                out_valid;
    logic                out_stall   = 1'b0;
    out_item_t           out_item;
    logic                cfg_wr_en   = 1'b0;
    logic [CFG_W-1:0]    cfg_wr_data = '0;

    block_map_scoreboard sb;
    int unsigned         answered_items = 0;
    int unsigned         in_steady = 0;
    int unsigned         quiet_cycles = 0;

    indirect_block_map_walker dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .in_item     (in_item),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_item    (out_item),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Short gaps mostly, a few long ones, now and then a run with none
    function automatic int unsigned in_gap();
        int unsigned r;
        if (in_steady != 0)
        begin
            in_steady--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 4)
        begin
            in_steady = $urandom_range(15, 40);
            return 0;
        end
        if (r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(12, 40);
    endfunction

    function automatic int unsigned stall_len();
        return ($urandom_range(0, 9) == 0) ? $urandom_range(15, 40) : $urandom_range(1, 3);
    endfunction

    function automatic logic [WORD_W-1:0] rand_block();
        logic [WORD_W-1:0] b;
        b = ($urandom_range(0, 3) == 0) ? 32'($urandom_range(1, 255)) : 32'($urandom);
        return (b == '0) ? 32'd1 : b;
    endfunction

    // Favor the indirect roots so walks go deep
    function automatic logic [SLOT_IN_W-1:0] rand_slot();
        return ($urandom_range(0, 2) == 0) ? 4'($urandom_range(DIRECT, ROOT_COUNT - 1))
                                           : 4'($urandom_range(0, 15));
    endfunction

    // Pick a file block index in one of the map regions, edges included
    function automatic logic [WORD_W-1:0] pick_index(int unsigned wl);
        longint unsigned per, lo, span, r;
        per = 64'd1 << wl;
        case ($urandom_range(0, 4))
            0:
            begin
                lo = 0;
                span = DIRECT;
            end
            1:
            begin
                lo = DIRECT;
                span = per;
            end
            2:
            begin
                lo = DIRECT + per;
                span = per * per;
            end
            3:
            begin
                lo = DIRECT + per + per * per;
                span = per * per * per;
            end
            default:
            begin
                lo = DIRECT + per + per * per + per * per * per;
                span = WORD_SPAN;
            end
        endcase
        if (lo >= WORD_SPAN)
            lo = 0;
        if (lo + span > WORD_SPAN)
            span = WORD_SPAN - lo;
        r = {$urandom, $urandom};
        case ($urandom_range(0, 5))
            0:       return 32'(lo);
            1:       return 32'(lo + span - 1);
            default: return 32'(lo + r % span);
        endcase
    endfunction

    // Hold the transfer until accepted, predict, then maybe pause
    task automatic send_item(input in_item_t it);
        int unsigned gap;
        in_valid <= 1'b1;
        in_item <= it;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        if (sb.note_input(it) != 0)
            answered_items++;
        gap = in_gap();
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Put the value in the field the op reads; randomize the rest
    task automatic drive_op(input logic [OP_W-1:0] op, input logic [SLOT_IN_W-1:0] slot,
                            input logic [WORD_W-1:0] value);
        in_item_t it;
        it.op               = op;
        it.slot             = slot;
        it.root_value       = $urandom;
        it.file_block_index = $urandom;
        it.read_word        = $urandom;
        it.new_block        = $urandom;
        case (op)
            OP_SET_ROOT:               it.root_value = value;
            OP_LOOKUP, OP_LOOKUP_ALLOC: it.file_block_index = value;
            OP_READ_RESP:              it.read_word = value;
            OP_ALLOC_RESP:             it.new_block = value;
            default:                   ;
        endcase
        send_item(it);
    endtask

    // Drain, let ignored transfers settle, then write the block size
    task automatic reconfigure(input logic [CFG_W-1:0] value);
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        sb.set_words_log2(value);
    endtask

    // Output side back-pressure
    initial
    begin
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                out_stall <= 1'b0;
                repeat ($urandom_range(20, 60)) @(posedge clk);
            end
            else
            begin
                out_stall <= 1'b1;
                repeat (stall_len()) @(posedge clk);
                out_stall <= 1'b0;
                repeat ($urandom_range(1, 4)) @(posedge clk);
            end
        end
    end

    // Check each output transfer; end the run if nothing moves for too long
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
                sb.check_result(out_item);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet_cycles <= 0;
            else if (quiet_cycles >= IDLE_LIMIT)
            begin
                $display("testbench: done, errors");
                $finish;
            end
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial
    begin
        int unsigned      first_answered;
        logic [CFG_W-1:0] block_sizes [6];
        sb = new();
        block_sizes = '{4'd12, 4'd0, 4'd15, 4'd10, 4'd9, 4'd11};
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // Below the legal range: clamps to 256 words per block
        reconfigure(4'd3);

        // Empty map, then direct slots and out-of-range slot
        drive_op(OP_READ_ROOT, 4'd0, '0);
        drive_op(OP_LOOKUP, 4'd0, 32'd0);
        drive_op(OP_SET_ROOT, 4'd0, 32'hFFFF_FFFF);
        drive_op(OP_READ_ROOT, 4'd0, '0);
        drive_op(OP_LOOKUP, 4'd0, 32'd0);
        drive_op(OP_SET_ROOT, 4'd15, 32'h1357_9BDF);
        drive_op(OP_READ_ROOT, 4'd15, '0);
        drive_op(OP_LOOKUP, 4'd0, 32'hFFFF_FFFF);

        // Allocation into a root slot: first no space, then success
        drive_op(OP_LOOKUP_ALLOC, 4'd0, 32'd11);
        drive_op(OP_ALLOC_RESP, 4'd0, 32'd0);
        drive_op(OP_LOOKUP_ALLOC, 4'd0, 32'd11);
        drive_op(OP_ALLOC_RESP, 4'd0, 32'h0000_1234);

        // Responses nobody waits for and unknown ops
        drive_op(OP_READ_RESP, 4'd0, 32'h55);
        drive_op(OP_ALLOC_RESP, 4'd0, 32'h66);
        drive_op(OP_SPARE_6, 4'd0, '0);
        drive_op(OP_SPARE_7, 4'd15, '1);

        // Start a triple indirect path from nothing; three blocks are granted and the walk waits for one more
        drive_op(OP_LOOKUP_ALLOC, 4'd0, 32'd65804);
        drive_op(OP_ALLOC_RESP, 4'd0, 32'hFFFF_FFFF);
        drive_op(OP_ALLOC_RESP, 4'd0, 32'd5);
        drive_op(OP_ALLOC_RESP, 4'd0, 32'd7);

        // Hole in a plain lookup, root write mid-walk, walk replaced
        drive_op(OP_LOOKUP, 4'd0, 32'd268);
        drive_op(OP_SET_ROOT, 4'd12, 32'h100);
        drive_op(OP_LOOKUP, 4'd0, 32'd267);
        drive_op(OP_SET_ROOT, 4'd3, 32'h3);
        drive_op(OP_READ_RESP, 4'd0, 32'd0);
        drive_op(OP_LOOKUP, 4'd0, 32'd12);
        drive_op(OP_LOOKUP, 4'd0, 32'd3);

        // Random traffic at each block size
        foreach (block_sizes[p])
        begin
            reconfigure(block_sizes[p]);
            first_answered = answered_items;
            while (answered_items - first_answered < ITEMS_PER_SIZE)
            begin
                case ($urandom_range(0, 9))
                    0:
                        drive_op(OP_SET_ROOT, rand_slot(),
                                 ($urandom_range(0, 3) == 0) ? 32'd0 : rand_block());
                    1:
                        drive_op(OP_READ_ROOT, rand_slot(), $urandom);
                    2:
                    begin
                        case ($urandom_range(0, 3))
                            0:       drive_op(OP_READ_RESP, rand_slot(), $urandom);
                            1:       drive_op(OP_ALLOC_RESP, rand_slot(), $urandom);
                            2:       drive_op(OP_SPARE_6, rand_slot(), $urandom);
                            default: drive_op(OP_SPARE_7, rand_slot(), $urandom);
                        endcase
                    end
                    default:
                    begin
                        // Follow one walk to its end, answering what it asks
                        drive_op($urandom_range(0, 1) ? OP_LOOKUP_ALLOC : OP_LOOKUP,
                                 rand_slot(), pick_index(sb.wlog2));
                        while (sb.phase != WALK_IDLE)
                        begin
                            if ($urandom_range(0, 15) == 0)
                            begin
                                case ($urandom_range(0, 4))
                                    0: drive_op(OP_SET_ROOT, rand_slot(), rand_block());
                                    1: drive_op(OP_READ_ROOT, rand_slot(), $urandom);
                                    2: drive_op((sb.phase == WALK_READ) ? OP_ALLOC_RESP
                                                                        : OP_READ_RESP,
                                                rand_slot(), $urandom);
                                    3: drive_op($urandom_range(0, 1) ? OP_SPARE_6
                                                                     : OP_SPARE_7,
                                                rand_slot(), $urandom);
                                    default:
                                        drive_op($urandom_range(0, 1) ? OP_LOOKUP_ALLOC
                                                                      : OP_LOOKUP,
                                                 rand_slot(), pick_index(sb.wlog2));
                                endcase
                            end
                            else if (sb.phase == WALK_READ)
                                drive_op(OP_READ_RESP, rand_slot(),
                                         ($urandom_range(0, 3) == 0) ? 32'd0 : rand_block());
                            else
                                drive_op(OP_ALLOC_RESP, rand_slot(),
                                         ($urandom_range(0, 9) == 0) ? 32'd0 : rand_block());
                        end
                    end
                endcase
            end
        end

        // Drain and give late or extra results time to show up
        in_valid <= 1'b0;
        while (sb.pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (sb.mismatches == 0 && sb.pending_results.size() == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+rtl
rtl/ibmw_pkg.sv
rtl/indirect_block_map_walker.sv
bench/testbench.sv
